/* rtl/core/tbc_pkg.sv */
// Shared constants and widths for the tetrahedron barycentric coordinate block.
package tbc_pkg;

  localparam int COORD_BITS = 21;
  localparam int PACK_W     = 63;
  localparam int SHAPE_W    = 32;
  localparam int FRAC_BITS  = 30;

  // Edge vectors, cross-product terms and triple products grow from the coordinates.
  localparam int DIFF_W  = COORD_BITS + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int TRI_W   = DIFF_W + CROSS_W + 2;

  // Divider operands: magnitudes of the determinant and the scaled numerators.
  localparam int MAG_W   = TRI_W;
  localparam int NUM_W   = MAG_W + FRAC_BITS;
  localparam int QS_W    = NUM_W + 1;
  localparam int SUM_W   = QS_W + 2;

  localparam logic [PACK_W-1:0] MIN_VOL_RESET = PACK_W'(1);

endpackage

/* rtl/core/tbc_in_if.sv */
// Input channel: four packed vertices and a query point per item.
interface tbc_in_if;
  import tbc_pkg::*;

  logic              valid;
  logic              ready;
  logic [PACK_W-1:0] vertex_0_xyz;
  logic [PACK_W-1:0] vertex_1_xyz;
  logic [PACK_W-1:0] vertex_2_xyz;
  logic [PACK_W-1:0] vertex_3_xyz;
  logic [PACK_W-1:0] point_xyz;

  modport source (
    output valid, vertex_0_xyz, vertex_1_xyz, vertex_2_xyz, vertex_3_xyz, point_xyz,
    input  ready
  );
  modport sink (
    input  valid, vertex_0_xyz, vertex_1_xyz, vertex_2_xyz, vertex_3_xyz, point_xyz,
    output ready
  );
endinterface

/* rtl/core/tbc_out_if.sv */
// Result channel: four barycentric weights and the degenerate flag per item.
interface tbc_out_if;
  import tbc_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [SHAPE_W-1:0] shape_0;
  logic signed [SHAPE_W-1:0] shape_1;
  logic signed [SHAPE_W-1:0] shape_2;
  logic signed [SHAPE_W-1:0] shape_3;
  logic                      degenerate;

  modport source (
    output valid, shape_0, shape_1, shape_2, shape_3, degenerate,
    input  ready
  );
  modport sink (
    input  valid, shape_0, shape_1, shape_2, shape_3, degenerate,
    output ready
  );
endinterface

/* rtl/core/tetra_barycentric_coords.sv */
// Pipelined tetrahedron barycentric weights with a bit-per-stage divider.
//
//   channel   direction  handshake        payload
//   in_if     in         valid/ready      vertex_0..3_xyz, point_xyz
//   out_if    out        valid/ready      shape_0..3, degenerate
//   cfg       in         cfg_we           cfg_wdata (min_volume6)
//
// One item enters per cycle unless the pipeline holds; the restoring divider retires
// one quotient bit per stage.
// rst_n is synchronous and clears all valid bits and sets min_volume6 to 1.
// The whole pipeline holds when the output register is full and out_if.ready is
// low; nothing is lost or repeated.
module tetra_barycentric_coords
  import tbc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  tbc_in_if.sink            in_if,
  tbc_out_if.source         out_if,
  input  logic              cfg_we,
  input  logic [PACK_W-1:0] cfg_wdata
);

  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [CROSS_W-1:0] cross_t;
  typedef logic signed [TRI_W-1:0]   tri_t;

  typedef struct packed {
    logic [2:0][MAG_W-1:0] rem;
    logic [2:0][NUM_W-1:0] num;
    logic [MAG_W-1:0]      den;
    logic [2:0]            neg;
    logic                  degen;
  } div_t;

  localparam logic signed [SUM_W-1:0] QONE = SUM_W'(1) << FRAC_BITS;

  logic              en;
  logic [PACK_W-1:0] min_vol_r;

  // Stage 1: edge vectors. Index 0..2 = v1, v2, v3, index 3 = p.
  diff_t  s1_vec_r [4][3];
  logic   s1_valid_r;
  // Stage 2: cross-product partial products. Index 0..2 = v2xv3, v3xv1, v1xv2.
  prod_t  s2_pa_r [3][3];
  prod_t  s2_pb_r [3][3];
  diff_t  s2_v1_r [3];
  diff_t  s2_p_r  [3];
  logic   s2_valid_r;
  // Stage 3: cross products.
  cross_t s3_cr_r [3][3];
  diff_t  s3_v1_r [3];
  diff_t  s3_p_r  [3];
  logic   s3_valid_r;
  // Stage 4: triple-product terms. Index 0 = det, 1..3 = n1..n3.
  tri_t   s4_tp_r [4][3];
  logic   s4_valid_r;
  // Stage 5: triple products.
  tri_t   s5_tri_r [4];
  logic   s5_valid_r;
  // Stage 6 and divider stages.
  div_t   div_r     [NUM_W+1];
  logic   div_vld_r [NUM_W+1];
  // Final stages.
  logic signed [QS_W-1:0]    f1_q_r [3];
  logic                      f1_degen_r;
  logic                      f1_valid_r;
  logic signed [SHAPE_W-1:0] out_shape_r [4];
  logic                      out_degen_r;
  logic                      out_valid_r;

  function automatic logic signed [SHAPE_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'({1'b0, {(SHAPE_W-1){1'b1}}});
    lo = -hi - SUM_W'(1);
    if (v > hi) return {1'b0, {(SHAPE_W-1){1'b1}}};
    else if (v < lo) return {1'b1, {(SHAPE_W-1){1'b0}}};
    else return v[SHAPE_W-1:0];
  endfunction

  assign en          = !out_valid_r || out_if.ready;
  assign in_if.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_vol_r <= MIN_VOL_RESET;
    end else if (cfg_we) begin
      min_vol_r <= cfg_wdata;
    end
  end

  // Valid chain.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      s5_valid_r  <= 1'b0;
      f1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i <= NUM_W; i++) div_vld_r[i] <= 1'b0;
    end else if (en) begin
      s1_valid_r   <= in_if.valid;
      s2_valid_r   <= s1_valid_r;
      s3_valid_r   <= s2_valid_r;
      s4_valid_r   <= s3_valid_r;
      s5_valid_r   <= s4_valid_r;
      div_vld_r[0] <= s5_valid_r;
      for (int i = 1; i <= NUM_W; i++) div_vld_r[i] <= div_vld_r[i-1];
      f1_valid_r   <= div_vld_r[NUM_W];
      out_valid_r  <= f1_valid_r;
    end
  end

  // Stage 1: unpack and subtract the base vertex.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s1_vec_r[0][k] <= DIFF_W'($signed(in_if.vertex_1_xyz[k*COORD_BITS +: COORD_BITS]))
                        - DIFF_W'($signed(in_if.vertex_0_xyz[k*COORD_BITS +: COORD_BITS]));
        s1_vec_r[1][k] <= DIFF_W'($signed(in_if.vertex_2_xyz[k*COORD_BITS +: COORD_BITS]))
                        - DIFF_W'($signed(in_if.vertex_0_xyz[k*COORD_BITS +: COORD_BITS]));
        s1_vec_r[2][k] <= DIFF_W'($signed(in_if.vertex_3_xyz[k*COORD_BITS +: COORD_BITS]))
                        - DIFF_W'($signed(in_if.vertex_0_xyz[k*COORD_BITS +: COORD_BITS]));
        s1_vec_r[3][k] <= DIFF_W'($signed(in_if.point_xyz[k*COORD_BITS +: COORD_BITS]))
                        - DIFF_W'($signed(in_if.vertex_0_xyz[k*COORD_BITS +: COORD_BITS]));
      end
    end
  end

  // Stage 2: b x c needs b[k+1]*c[k+2] and b[k+2]*c[k+1] per component k.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s2_pa_r[0][k] <= PROD_W'(s1_vec_r[1][(k+1)%3]) * PROD_W'(s1_vec_r[2][(k+2)%3]);
        s2_pb_r[0][k] <= PROD_W'(s1_vec_r[1][(k+2)%3]) * PROD_W'(s1_vec_r[2][(k+1)%3]);
        s2_pa_r[1][k] <= PROD_W'(s1_vec_r[2][(k+1)%3]) * PROD_W'(s1_vec_r[0][(k+2)%3]);
        s2_pb_r[1][k] <= PROD_W'(s1_vec_r[2][(k+2)%3]) * PROD_W'(s1_vec_r[0][(k+1)%3]);
        s2_pa_r[2][k] <= PROD_W'(s1_vec_r[0][(k+1)%3]) * PROD_W'(s1_vec_r[1][(k+2)%3]);
        s2_pb_r[2][k] <= PROD_W'(s1_vec_r[0][(k+2)%3]) * PROD_W'(s1_vec_r[1][(k+1)%3]);
        s2_v1_r[k]    <= s1_vec_r[0][k];
        s2_p_r[k]     <= s1_vec_r[3][k];
      end
    end
  end

  // Stage 3: cross products.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        for (int k = 0; k < 3; k++) begin
          s3_cr_r[c][k] <= CROSS_W'(s2_pa_r[c][k]) - CROSS_W'(s2_pb_r[c][k]);
        end
      end
      s3_v1_r <= s2_v1_r;
      s3_p_r  <= s2_p_r;
    end
  end

  // Stage 4: dot-product terms.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s4_tp_r[0][k] <= TRI_W'(s3_v1_r[k]) * TRI_W'(s3_cr_r[0][k]);
        s4_tp_r[1][k] <= TRI_W'(s3_p_r[k])  * TRI_W'(s3_cr_r[0][k]);
        s4_tp_r[2][k] <= TRI_W'(s3_p_r[k])  * TRI_W'(s3_cr_r[1][k]);
        s4_tp_r[3][k] <= TRI_W'(s3_p_r[k])  * TRI_W'(s3_cr_r[2][k]);
      end
    end
  end

  // Stage 5: sums.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int t = 0; t < 4; t++) begin
        s5_tri_r[t] <= s4_tp_r[t][0] + s4_tp_r[t][1] + s4_tp_r[t][2];
      end
    end
  end

  // Stage 6: magnitudes, signs and the degenerate test.
  logic [MAG_W-1:0] det_mag;
  assign det_mag = s5_tri_r[0][TRI_W-1] ? MAG_W'(-s5_tri_r[0]) : MAG_W'(s5_tri_r[0]);

  always_ff @(posedge clk) begin
    if (en) begin
      div_r[0].den   <= det_mag;
      div_r[0].degen <= (det_mag == '0) || (det_mag < MAG_W'(min_vol_r));
      for (int i = 0; i < 3; i++) begin
        div_r[0].rem[i] <= '0;
        div_r[0].neg[i] <= s5_tri_r[i+1][TRI_W-1] ^ s5_tri_r[0][TRI_W-1];
        div_r[0].num[i] <= {(s5_tri_r[i+1][TRI_W-1] ? MAG_W'(-s5_tri_r[i+1])
                                                     : MAG_W'(s5_tri_r[i+1])),
                            {FRAC_BITS{1'b0}}};
      end
    end
  end

  // Restoring division: each stage shifts one numerator bit into the remainder
  // and shifts one quotient bit into the freed low end of the numerator.
  for (genvar g = 1; g <= NUM_W; g++) begin : g_div
    logic [2:0][MAG_W:0] trial;
    logic [2:0]          fits;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        trial[i] = {div_r[g-1].rem[i], div_r[g-1].num[i][NUM_W-1]};
        fits[i]  = trial[i] >= {1'b0, div_r[g-1].den};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        div_r[g].den   <= div_r[g-1].den;
        div_r[g].neg   <= div_r[g-1].neg;
        div_r[g].degen <= div_r[g-1].degen;
        for (int i = 0; i < 3; i++) begin
          div_r[g].rem[i] <= fits[i] ? MAG_W'(trial[i] - {1'b0, div_r[g-1].den})
                                     : MAG_W'(trial[i]);
          div_r[g].num[i] <= {div_r[g-1].num[i][NUM_W-2:0], fits[i]};
        end
      end
    end
  end

  // Final stage 1: apply quotient signs.
  always_ff @(posedge clk) begin
    if (en) begin
      f1_degen_r <= div_r[NUM_W].degen;
      for (int i = 0; i < 3; i++) begin
        f1_q_r[i] <= div_r[NUM_W].neg[i] ? -$signed({1'b0, div_r[NUM_W].num[i]})
                                         :  $signed({1'b0, div_r[NUM_W].num[i]});
      end
    end
  end

  // Final stage 2: first weight by difference, saturation, zeroing when degenerate.
  logic signed [SUM_W-1:0] q0_sum;
  assign q0_sum = QONE - SUM_W'(f1_q_r[0]) - SUM_W'(f1_q_r[1]) - SUM_W'(f1_q_r[2]);

  always_ff @(posedge clk) begin
    if (en) begin
      out_degen_r <= f1_degen_r;
      if (f1_degen_r) begin
        for (int i = 0; i < 4; i++) out_shape_r[i] <= '0;
      end else begin
        out_shape_r[0] <= sat32(q0_sum);
        for (int i = 0; i < 3; i++) out_shape_r[i+1] <= sat32(SUM_W'(f1_q_r[i]));
      end
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.shape_0    = out_shape_r[0];
  assign out_if.shape_1    = out_shape_r[1];
  assign out_if.shape_2    = out_shape_r[2];
  assign out_if.shape_3    = out_shape_r[3];
  assign out_if.degenerate = out_degen_r;

`ifndef SYNTHESIS
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.degenerate |->
      out_if.shape_0 == '0 && out_if.shape_1 == '0 &&
      out_if.shape_2 == '0 && out_if.shape_3 == '0)
    else $error("degenerate item with nonzero weights");

  a_sum_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && !out_if.degenerate &&
    out_if.shape_0 != {1'b0, {(SHAPE_W-1){1'b1}}} &&
    out_if.shape_0 != {1'b1, {(SHAPE_W-1){1'b0}}} &&
    out_if.shape_1 != {1'b0, {(SHAPE_W-1){1'b1}}} &&
    out_if.shape_1 != {1'b1, {(SHAPE_W-1){1'b0}}} &&
    out_if.shape_2 != {1'b0, {(SHAPE_W-1){1'b1}}} &&
    out_if.shape_2 != {1'b1, {(SHAPE_W-1){1'b0}}} &&
    out_if.shape_3 != {1'b0, {(SHAPE_W-1){1'b1}}} &&
    out_if.shape_3 != {1'b1, {(SHAPE_W-1){1'b0}}} |->
      (SHAPE_W+2)'(out_if.shape_0) + (SHAPE_W+2)'(out_if.shape_1) +
      (SHAPE_W+2)'(out_if.shape_2) + (SHAPE_W+2)'(out_if.shape_3) ==
      (SHAPE_W+2)'(1) << FRAC_BITS)
    else $error("unsaturated weights do not sum to one");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_if.valid |-> in_if.ready)
    else $error("input stalled with an empty output register");

  a_stall_hold_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && !out_if.ready |=> $stable(f1_valid_r) && $stable(div_vld_r[NUM_W]))
    else $error("pipeline moved during a stall");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_if.valid)
    else $error("result valid right after reset");
`endif

endmodule

/* verif/tb_tetra_barycentric_coords.sv */
// Self-checking testbench for the tetrahedron barycentric weight pipeline.
`timescale 1ns / 1ps

module tb_tetra_barycentric_coords;
  import tbc_pkg::*;

  typedef struct packed {
    logic [PACK_W-1:0] v0;
    logic [PACK_W-1:0] v1;
    logic [PACK_W-1:0] v2;
    logic [PACK_W-1:0] v3;
    logic [PACK_W-1:0] pt;
  } tetra_t;

  typedef struct packed {
    logic signed [SHAPE_W-1:0] s0;
    logic signed [SHAPE_W-1:0] s1;
    logic signed [SHAPE_W-1:0] s2;
    logic signed [SHAPE_W-1:0] s3;
    logic                      degen;
  } weights_t;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_WAIT  = 150;
  localparam int LONG_HOLD   = 400;
  localparam int CMAX        = (1 << (COORD_BITS - 1)) - 1;
  localparam int CMIN        = -(1 << (COORD_BITS - 1));

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [PACK_W-1:0] cfg_wdata = '0;

  tbc_in_if  in_ch ();
  tbc_out_if out_ch ();

  tetra_barycentric_coords dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  tetra_t   pending_tetra[$];
  weights_t weight_q[$];
  logic [PACK_W-1:0] min_vol_shadow = MIN_VOL_RESET;

  int unsigned cycles = 0;
  int unsigned n_sent = 0;
  int unsigned n_recv = 0;
  int unsigned n_degen = 0;
  int unsigned n_errors = 0;
  int unsigned n_settings = 1;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  int unsigned hold_cnt = 0;
  bit long_hold_done = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.vertex_0_xyz = '0;
    in_ch.vertex_1_xyz = '0;
    in_ch.vertex_2_xyz = '0;
    in_ch.vertex_3_xyz = '0;
    in_ch.point_xyz = '0;
    out_ch.ready = 1'b0;
  end

  function automatic logic signed [127:0] coord_of(logic [PACK_W-1:0] p, int k);
    logic signed [COORD_BITS-1:0] raw;
    logic signed [127:0] r;
    raw = p[k*COORD_BITS +: COORD_BITS];
    r = raw;
    return r;
  endfunction

  // a . (b x c)
  function automatic logic signed [127:0] triple3(
    logic signed [127:0] ax, logic signed [127:0] ay, logic signed [127:0] az,
    logic signed [127:0] bx, logic signed [127:0] by, logic signed [127:0] bz,
    logic signed [127:0] cx, logic signed [127:0] cy, logic signed [127:0] cz);
    return ax * (by * cz - bz * cy) + ay * (bz * cx - bx * cz) + az * (bx * cy - by * cx);
  endfunction

  function automatic logic signed [SHAPE_W-1:0] clamp32(logic signed [127:0] a);
    if (a > 128'sd2147483647) return 32'sh7FFF_FFFF;
    if (a < -128'sd2147483648) return 32'sh8000_0000;
    return a[SHAPE_W-1:0];
  endfunction

  function automatic weights_t solve_weights(tetra_t t, logic [PACK_W-1:0] thr);
    logic signed [127:0] o[3], e1[3], e2[3], e3[3], d[3];
    logic signed [127:0] det, mag, n1, n2, n3, q1, q2, q3, q0;
    weights_t w;
    for (int k = 0; k < 3; k++) begin
      o[k]  = coord_of(t.v0, k);
      e1[k] = coord_of(t.v1, k) - o[k];
      e2[k] = coord_of(t.v2, k) - o[k];
      e3[k] = coord_of(t.v3, k) - o[k];
      d[k]  = coord_of(t.pt, k) - o[k];
    end
    det = triple3(e1[0], e1[1], e1[2], e2[0], e2[1], e2[2], e3[0], e3[1], e3[2]);
    mag = (det < 0) ? -det : det;
    w = '0;
    if (det == 0 || $unsigned(mag) < {65'b0, thr}) begin
      w.degen = 1'b1;
      return w;
    end
    n1 = triple3(d[0], d[1], d[2], e2[0], e2[1], e2[2], e3[0], e3[1], e3[2]);
    n2 = triple3(d[0], d[1], d[2], e3[0], e3[1], e3[2], e1[0], e1[1], e1[2]);
    n3 = triple3(d[0], d[1], d[2], e1[0], e1[1], e1[2], e2[0], e2[1], e2[2]);
    // Signed division truncates toward zero, as the block does.
    q1 = (n1 <<< FRAC_BITS) / det;
    q2 = (n2 <<< FRAC_BITS) / det;
    q3 = (n3 <<< FRAC_BITS) / det;
    q0 = (128'sd1 <<< FRAC_BITS) - q1 - q2 - q3;
    w.s0 = clamp32(q0);
    w.s1 = clamp32(q1);
    w.s2 = clamp32(q2);
    w.s3 = clamp32(q3);
    return w;
  endfunction

  function automatic logic [PACK_W-1:0] pk(int x, int y, int z);
    logic [COORD_BITS-1:0] a, b, c;
    a = x[COORD_BITS-1:0];
    b = y[COORD_BITS-1:0];
    c = z[COORD_BITS-1:0];
    return {c, b, a};
  endfunction

  function automatic logic [PACK_W-1:0] rand_word();
    return PACK_W'({$urandom, $urandom});
  endfunction

  function automatic int near(int c, int span);
    int v;
    v = c + $urandom_range(0, 2 * span) - span;
    if (v > CMAX) v = CMAX;
    if (v < CMIN) v = CMIN;
    return v;
  endfunction

  function automatic logic [PACK_W-1:0] near_pt(int cx, int cy, int cz, int span);
    return pk(near(cx, span), near(cy, span), near(cz, span));
  endfunction

  function automatic tetra_t random_tetra();
    tetra_t t;
    int cx, cy, cz, span, kind;
    kind = $urandom_range(0, 9);
    cx = $urandom_range(0, 2 * CMAX) - CMAX;
    cy = $urandom_range(0, 2 * CMAX) - CMAX;
    cz = $urandom_range(0, 2 * CMAX) - CMAX;
    span = (kind < 5) ? $urandom_range(1, 2000) : $urandom_range(1, 200000);
    t.v0 = near_pt(cx, cy, cz, span);
    t.v1 = near_pt(cx, cy, cz, span);
    t.v2 = near_pt(cx, cy, cz, span);
    t.v3 = near_pt(cx, cy, cz, span);
    t.pt = near_pt(cx, cy, cz, 2 * span);
    if (kind == 7) begin
      t = {rand_word(), rand_word(), rand_word(), rand_word(), rand_word()};
    end else if (kind == 8) begin
      // Coplanar or repeated vertices give a zero determinant.
      if ($urandom_range(0, 1)) t.v3 = t.v1;
      else t.v3 = pk(cx, cy, cz);
      if (t.v3 != t.v1) begin
        t.v0 = pk(cx, cy, cz);
        t.v1 = pk(cx + 5, cy, cz);
        t.v2 = pk(cx, cy + 7, cz);
        t.v3 = pk(cx + $urandom_range(0, 9), cy + $urandom_range(0, 9), cz);
      end
    end else if (kind == 9) begin
      t.pt = rand_word();
    end
    // Set the top bit at random on two of the fields.
    t.v0[PACK_W-1] = 1'($urandom_range(0, 1));
    t.pt[PACK_W-1] = 1'($urandom_range(0, 1));
    return t;
  endfunction

  // Appends one item to the end of the pending queue.
  function automatic void queue_item(tetra_t t);
    pending_tetra.insert(pending_tetra.size(), t);
  endfunction

  // Driver: offers queued items with random gaps between them.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_ch.ready) begin
      // holding the current item
    end else begin
      if (in_ch.valid) begin
        weight_q.insert(weight_q.size(),
          solve_weights({in_ch.vertex_0_xyz, in_ch.vertex_1_xyz,
          in_ch.vertex_2_xyz, in_ch.vertex_3_xyz, in_ch.point_xyz}, min_vol_shadow));
        n_sent <= n_sent + 1;
        case ($urandom_range(0, 19))
          0: send_gap = $urandom_range(10, 40);
          1, 2, 3, 4, 5: send_gap = $urandom_range(1, 3);
          default: send_gap = 0;
        endcase
      end
      if (send_gap > 0) begin
        send_gap = send_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (pending_tetra.size() > 0) begin
        tetra_t t;
        t = pending_tetra.pop_front();
        in_ch.vertex_0_xyz <= t.v0;
        in_ch.vertex_1_xyz <= t.v1;
        in_ch.vertex_2_xyz <= t.v2;
        in_ch.vertex_3_xyz <= t.v3;
        in_ch.point_xyz <= t.pt;
        in_ch.valid <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver ready: random stalls plus one long hold-off while the sender keeps going.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ch.ready <= 1'b0;
    end else if (!long_hold_done && n_sent > 300) begin
      long_hold_done <= 1;
      hold_cnt <= LONG_HOLD;
      out_ch.ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      out_ch.ready <= 1'b0;
    end else begin
      case ($urandom_range(0, 19))
        0: recv_gap <= $urandom_range(10, 40);
        1, 2, 3, 4: recv_gap <= $urandom_range(1, 3);
        default: recv_gap <= 0;
      endcase
      out_ch.ready <= 1'b1;
    end
  end

  // Monitor: compares each accepted result with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      weights_t got, want;
      got = {out_ch.shape_0, out_ch.shape_1, out_ch.shape_2, out_ch.shape_3,
             out_ch.degenerate};
      n_recv <= n_recv + 1;
      if (weight_q.size() == 0) begin
        n_errors = n_errors + 1;
        if (n_errors <= 10) $display("ERROR: unexpected result %p", got);
      end else begin
        want = weight_q.pop_front();
        if (want.degen) n_degen <= n_degen + 1;
        if (got !== want) begin
          n_errors = n_errors + 1;
          if (n_errors <= 10)
            $display("ERROR: result %0d expected %0d %0d %0d %0d deg=%0b got %0d %0d %0d %0d deg=%0b",
                     n_recv, want.s0, want.s1, want.s2, want.s3, want.degen,
                     got.s0, got.s1, got.s2, got.s3, got.degen);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_tetra_barycentric_coords failed");
      $finish;
    end
  end

  task automatic wait_idle();
    while (pending_tetra.size() > 0 || in_ch.valid || weight_q.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_threshold(logic [PACK_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    min_vol_shadow = v;
    n_settings++;
  endtask

  task automatic add_directed();
    tetra_t t;
    // Unit tetrahedron with the point on each vertex and at points outside it.
    t.v0 = pk(0, 0, 0); t.v1 = pk(1, 0, 0); t.v2 = pk(0, 1, 0); t.v3 = pk(0, 0, 1);
    for (int i = 0; i < 4; i++) begin
      t.pt = (i == 0) ? t.v0 : (i == 1) ? t.v1 : (i == 2) ? t.v2 : t.v3;
      queue_item(t);
    end
    t.pt = pk(CMAX, CMAX, CMAX);  queue_item(t);   // saturates high
    t.pt = pk(CMIN, CMIN, CMIN);  queue_item(t);   // saturates low
    t.pt = pk(-1, 0, 0);          queue_item(t);
    // Swapped vertices give a negative determinant.
    t.v1 = pk(0, 1, 0); t.v2 = pk(1, 0, 0); t.pt = pk(1, 1, 1);
    queue_item(t);
    // Right-corner tetrahedron with unequal edges, point inside with non-exact quotients.
    t.v0 = pk(0, 0, 0); t.v1 = pk(3, 0, 0); t.v2 = pk(0, 7, 0); t.v3 = pk(0, 0, 11);
    t.pt = pk(1, 2, 3); queue_item(t);
    // Largest extent in every coordinate.
    t.v0 = pk(CMIN, CMIN, CMIN); t.v1 = pk(CMAX, CMIN, CMIN);
    t.v2 = pk(CMIN, CMAX, CMIN); t.v3 = pk(CMIN, CMIN, CMAX);
    t.pt = pk(0, 0, 0); queue_item(t);
    t.pt = pk(CMAX, CMAX, CMAX); queue_item(t);
    t.v1 = pk(CMAX, CMAX, CMIN); t.pt = pk(CMIN, CMAX, CMAX); queue_item(t);
    // Degenerate: repeated vertex, collinear points, all zero.
    t.v0 = pk(5, 5, 5); t.v1 = pk(5, 5, 5); t.v2 = pk(9, 1, 2); t.v3 = pk(3, 3, 8);
    t.pt = pk(1, 1, 1); queue_item(t);
    t.v1 = pk(6, 6, 6); t.v2 = pk(7, 7, 7); t.v3 = pk(8, 8, 8); queue_item(t);
    queue_item('0);
    // Top bit set on every field.
    t.v0 = pk(0, 0, 0) | (63'b1 << 62);
    t.v0[PACK_W-1] = 1'b1;
    t.v1 = pk(4, 0, 0); t.v2 = pk(0, 4, 0); t.v3 = pk(0, 0, 4); t.pt = pk(1, 1, 1);
    t.v1[PACK_W-1] = 1'b1; t.v2[PACK_W-1] = 1'b1; t.v3[PACK_W-1] = 1'b1;
    t.pt[PACK_W-1] = 1'b1;
    queue_item(t);
    // Every field all ones and alternating patterns.
    queue_item('1);
    queue_item({5{63'h2AAA_AAAA_AAAA_AAAA}});
    queue_item({5{63'h5555_5555_5555_5555}});
  endtask

  initial begin
    logic [PACK_W-1:0] settings[6];
    settings[0] = MIN_VOL_RESET;
    settings[1] = '0;
    settings[2] = 63'd1 << 20;
    settings[3] = {1'b0, $urandom_range(1, 255), 30'b0};
    settings[4] = '1;
    settings[5] = 63'd1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    add_directed();
    wait_idle();
    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) write_threshold(settings[ph]);
      for (int i = 0; i < 220; i++) queue_item(random_tetra());
      wait_idle();
    end
    if (weight_q.size() > 0) n_errors = n_errors + weight_q.size();
    $display("Sent %0d items and checked %0d results (%0d degenerate) over %0d thresholds.",
             n_sent, n_recv, n_degen, n_settings);
    $display("Included a %0d-cycle receiver hold-off and %0d mismatches.", LONG_HOLD, n_errors);
    if (n_errors == 0) begin
      $display("tb_tetra_barycentric_coords passed");
    end else begin
      $display("tb_tetra_barycentric_coords failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/tbc_pkg.sv
rtl/core/tbc_in_if.sv
rtl/core/tbc_out_if.sv
rtl/core/tetra_barycentric_coords.sv
verif/tb_tetra_barycentric_coords.sv
